// ===== hw/rtl/tmr_pkg.sv =====
// ---------------------------------------------------------------------------
// tmr_pkg
// Shared types, constants and SHA-256 tables for the taproot Merkle path core.
// ---------------------------------------------------------------------------
package tmr_pkg;

  localparam int WORD_W  = 64;
  localparam int SHA_W   = 32;
  localparam int HASH_WORDS = 4;
  localparam int ROUNDS  = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SHA_W-1:0]  sword_t;
  typedef logic [1:0]        wpos_t;
  typedef logic [6:0]        rcnt_t;
  typedef logic [5:0]        ridx_t;

  // Block source; the chaining value in use follows from it.
  typedef enum logic [1:0] {
    BLK_TAG  = 2'd0,  // "TapBranch" padded, from IV
    BLK_TT   = 2'd1,  // tag || tag, from IV
    BLK_PAIR = 2'd2,  // ordered node/sibling, from midstate
    BLK_PAD  = 2'd3   // length block, from current digest
  } blk_sel_t;

  typedef struct packed {
    logic     wr_word;
    logic     load;
    blk_sel_t blk_sel;
    logic     round;
    ridx_t    rnd;
    logic     finish;
    logic     save_mid;
    logic     save_node;
    wpos_t    out_idx;
  } cmd_t;

  typedef struct packed {
    logic last_word;
  } sts_t;

  localparam sword_t TAG_W0  = 32'h54617042;
  localparam sword_t TAG_W1  = 32'h72616e63;
  localparam sword_t TAG_W2  = 32'h68800000;
  localparam sword_t TAG_LEN = 32'd72;
  localparam sword_t PAD_W0  = 32'h80000000;
  localparam sword_t PAD_LEN = 32'd1024;

  function automatic sword_t sha_iv(input logic [2:0] i);
    sword_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic sword_t sha_k(input ridx_t i);
    sword_t r;
    case (i)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491; 6'd2:  r = 32'hb5c0fbcf;
      6'd3:  r = 32'he9b5dba5; 6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5; 6'd8:  r = 32'hd807aa98;
      6'd9:  r = 32'h12835b01; 6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe; 6'd14: r = 32'h9bdc06a7;
      6'd15: r = 32'hc19bf174; 6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc; 6'd20: r = 32'h2de92c6f;
      6'd21: r = 32'h4a7484aa; 6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d; 6'd26: r = 32'hb00327c8;
      6'd27: r = 32'hbf597fc7; 6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967; 6'd32: r = 32'h27b70a85;
      6'd33: r = 32'h2e1b2138; 6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb; 6'd38: r = 32'h81c2c92e;
      6'd39: r = 32'h92722c85; 6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3; 6'd44: r = 32'hd192e819;
      6'd45: r = 32'hd6990624; 6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08; 6'd50: r = 32'h2748774c;
      6'd51: r = 32'h34b0bcb5; 6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3; 6'd56: r = 32'h748f82ee;
      6'd57: r = 32'h78a5636f; 6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb; 6'd62: r = 32'hbef9a3f7;
      default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic sword_t rotr(input sword_t x, input int n);
    return (x >> n) | (x << (SHA_W - n));
  endfunction

endpackage

// ===== hw/rtl/tmr_ctrl.sv =====
// ---------------------------------------------------------------------------
// tmr_ctrl
// Sequencer: midstate setup after reset, word intake, two compressions per
// sibling and the four-word root readout.
// ---------------------------------------------------------------------------
module tmr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          in_kind,
  input  logic          in_end_of_path,
  output logic          out_valid,
  input  logic          out_stall,
  input  tmr_pkg::sts_t sts,
  output tmr_pkg::cmd_t cmd
);
  import tmr_pkg::*;

  typedef enum logic [5:0] {
    ST_TAG  = 6'b000001,
    ST_MID  = 6'b000010,
    ST_IDLE = 6'b000100,
    ST_PAIR = 6'b001000,
    ST_PAD  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  localparam rcnt_t CNT_FIN = rcnt_t'(ROUNDS + 1);

  state_t state_r, state_nxt;
  rcnt_t  cnt_r, cnt_nxt;
  wpos_t  ocnt_r, ocnt_nxt;
  logic   end_r, end_nxt;
  rcnt_t  cnt_m1;

  assign cnt_m1 = cnt_r - rcnt_t'(1);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ocnt_nxt  = ocnt_r;
    end_nxt   = end_r;
    cmd       = '0;
    cmd.rnd   = cnt_m1[5:0];
    cmd.out_idx = ocnt_r;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_TAG, ST_MID, ST_PAIR, ST_PAD: begin
        unique case (state_r)
          ST_TAG:  cmd.blk_sel = BLK_TAG;
          ST_MID:  cmd.blk_sel = BLK_TT;
          ST_PAIR: cmd.blk_sel = BLK_PAIR;
          default: cmd.blk_sel = BLK_PAD;
        endcase
        cnt_nxt = cnt_r + rcnt_t'(1);
        if (cnt_r == '0) begin
          cmd.load = 1'b1;
        end else if (cnt_r != CNT_FIN) begin
          cmd.round = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          cnt_nxt = '0;
          unique case (state_r)
            ST_TAG:  state_nxt = ST_MID;
            ST_MID: begin
              cmd.save_mid = 1'b1;
              state_nxt = ST_IDLE;
            end
            ST_PAIR: state_nxt = ST_PAD;
            default: begin
              cmd.save_node = 1'b1;
              state_nxt = end_r ? ST_OUT : ST_IDLE;
            end
          endcase
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.wr_word = 1'b1;
          end_nxt = in_end_of_path;
          if (sts.last_word) begin
            if (in_kind) begin
              state_nxt = ST_PAIR;
            end else if (in_end_of_path) begin
              state_nxt = ST_OUT;
            end
          end
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          ocnt_nxt = ocnt_r + wpos_t'(1);
          if (ocnt_r == wpos_t'(HASH_WORDS - 1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAG;
      cnt_r   <= '0;
      ocnt_r  <= '0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ocnt_r  <= ocnt_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// ===== hw/rtl/tmr_dp.sv =====
// ---------------------------------------------------------------------------
// tmr_dp
// Datapath: node and sibling words, pair ordering, one SHA-256 round per
// cycle with a rolling 16-word schedule window, midstate and root readout.
// ---------------------------------------------------------------------------
module tmr_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  tmr_pkg::cmd_t   cmd,
  output tmr_pkg::sts_t   sts,
  input  logic            in_kind,
  input  tmr_pkg::word_t  in_hash_word,
  output tmr_pkg::word_t  out_root_word,
  output logic            out_root_last
);
  import tmr_pkg::*;

  word_t  node_r [HASH_WORDS];
  word_t  sib_r  [HASH_WORDS];
  wpos_t  pos_r;
  sword_t dig_r  [8];
  sword_t mid_r  [8];
  sword_t v_r    [8];
  sword_t sch_r  [16];

  sword_t blk    [16];
  sword_t chain  [8];
  sword_t sum    [8];
  logic [255:0] node_cat, sib_cat;
  logic   swap;
  sword_t w_new, t1, t2, s0, s1, bs0, bs1, ch, mj;

  assign sts.last_word = (pos_r == wpos_t'(HASH_WORDS - 1));
  assign out_root_word = node_r[cmd.out_idx];
  assign out_root_last = (cmd.out_idx == wpos_t'(HASH_WORDS - 1));

  assign node_cat = {node_r[0], node_r[1], node_r[2], node_r[3]};
  assign sib_cat  = {sib_r[0], sib_r[1], sib_r[2], sib_r[3]};
  // sibling leads only when strictly smaller
  assign swap = sib_cat < node_cat;

  always_comb begin
    for (int i = 0; i < 16; i++) blk[i] = '0;
    for (int i = 0; i < 8; i++) chain[i] = sha_iv(3'(i));
    case (cmd.blk_sel)
      BLK_TAG: begin
        blk[0] = TAG_W0; blk[1] = TAG_W1; blk[2] = TAG_W2; blk[15] = TAG_LEN;
      end
      BLK_TT: begin
        for (int i = 0; i < 8; i++) begin
          blk[i] = dig_r[i];
          blk[i+8] = dig_r[i];
        end
      end
      BLK_PAIR: begin
        for (int i = 0; i < HASH_WORDS; i++) begin
          blk[2*i]     = swap ? sib_r[i][63:32]  : node_r[i][63:32];
          blk[2*i+1]   = swap ? sib_r[i][31:0]   : node_r[i][31:0];
          blk[8+2*i]   = swap ? node_r[i][63:32] : sib_r[i][63:32];
          blk[8+2*i+1] = swap ? node_r[i][31:0]  : sib_r[i][31:0];
        end
        for (int i = 0; i < 8; i++) chain[i] = mid_r[i];
      end
      default: begin
        blk[0] = PAD_W0; blk[15] = PAD_LEN;
        for (int i = 0; i < 8; i++) chain[i] = dig_r[i];
      end
    endcase
  end

  always_comb begin
    s0  = rotr(sch_r[1], 7) ^ rotr(sch_r[1], 18) ^ (sch_r[1] >> 3);
    s1  = rotr(sch_r[14], 17) ^ rotr(sch_r[14], 19) ^ (sch_r[14] >> 10);
    w_new = sch_r[0] + s0 + sch_r[9] + s1;
    bs1 = rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25);
    ch  = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    bs0 = rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22);
    mj  = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t1  = v_r[7] + bs1 + ch + sha_k(cmd.rnd) + sch_r[0];
    t2  = bs0 + mj;
    for (int i = 0; i < 8; i++) sum[i] = dig_r[i] + v_r[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.wr_word) begin
      pos_r <= pos_r + wpos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_word) begin
      if (in_kind) sib_r[pos_r] <= in_hash_word;
      else         node_r[pos_r] <= in_hash_word;
    end
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) sch_r[i] <= blk[i];
      for (int i = 0; i < 8; i++) begin
        v_r[i]   <= chain[i];
        dig_r[i] <= chain[i];
      end
    end
    if (cmd.round) begin
      for (int i = 0; i < 15; i++) sch_r[i] <= sch_r[i+1];
      sch_r[15] <= w_new;
      v_r[7] <= v_r[6]; v_r[6] <= v_r[5]; v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2]; v_r[2] <= v_r[1]; v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 8; i++) dig_r[i] <= sum[i];
    end
    if (cmd.save_mid) begin
      for (int i = 0; i < 8; i++) mid_r[i] <= sum[i];
    end
    if (cmd.save_node) begin
      for (int i = 0; i < HASH_WORDS; i++) node_r[i] <= {sum[2*i], sum[2*i+1]};
    end
  end

endmodule

// ===== hw/rtl/taproot_merkle_path_root_core.sv =====
// ---------------------------------------------------------------------------
// taproot_merkle_path_root_core
// Merkle root of one taproot script path: leaf hash, then sibling hashes,
// each folded in with a tagged TapBranch SHA-256.
// ---------------------------------------------------------------------------
//  channel | ports                                   | moves
//  in      | in_valid in_stall in_kind in_hash_word  | one hash word per
//          | in_end_of_path                          | transaction
//  out     | out_valid out_stall out_root_word       | four root words,
//          | out_root_last                           | last flagged
//
//  A word is taken when in_valid is high and in_stall is low. The fourth
//  word of a sibling starts two compressions (load, 64 rounds, add) on the
//  single round unit; input is stalled until both are done.
//  After reset the tag midstate is computed first, with in_stall held
//  high. Input is stalled while the root words are read out.
// ---------------------------------------------------------------------------
module taproot_merkle_path_root_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_kind,
  input  tmr_pkg::word_t in_hash_word,
  input  logic           in_end_of_path,
  output logic           out_valid,
  input  logic           out_stall,
  output tmr_pkg::word_t out_root_word,
  output logic           out_root_last
);
  import tmr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  tmr_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_end_of_path (in_end_of_path),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  tmr_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_kind       (in_kind),
    .in_hash_word  (in_hash_word),
    .out_root_word (out_root_word),
    .out_root_last (out_root_last)
  );

endmodule

// ===== hw/rtl/tmr_checker.sv =====
// ---------------------------------------------------------------------------
// tmr_checker
// Port-level checks on the Merkle path core, bound to the top level.
// ---------------------------------------------------------------------------
module tmr_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input tmr_pkg::word_t out_root_word,
  input logic           out_root_last
);
  import tmr_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_root_word)
      && $stable(out_root_last))
    else $error("stalled root word changed");

  // stalled input transaction is held by the sender
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid)
    else $error("stalled input dropped");

  // no input taken while the root is read out
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during readout");

  // readout ends after the last word
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_root_last |=> !out_valid)
    else $error("result after last root word");

  // midstate setup after reset blocks input
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> in_stall && !out_valid)
    else $error("not busy after reset");

endmodule

bind taproot_merkle_path_root_core tmr_checker u_tmr_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_root_word (out_root_word),
  .out_root_last (out_root_last)
);
